// File: rtl/wals_pkg.sv
// Shared types and constants for the windowed audio level statistics block.
// Holds field widths, register indexes, the per-window record and queue status.
// No dependencies.
package wals_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int WIN_W       = 16;
  localparam int RATE_W      = 18;
  localparam int CNT_W       = 16;
  localparam int WNUM_W      = 32;
  localparam int OUT_W       = 16;
  localparam int ZC_W        = 18;
  localparam int SUM_W       = SAMPLE_BITS + 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int SQ_ACC_W    = 2 * SAMPLE_BITS + 14;
  localparam int PROD_W      = CNT_W + RATE_W;
  localparam int DIV_W       = (SQ_ACC_W > PROD_W) ? SQ_ACC_W : PROD_W;
  localparam int STEP_W      = $clog2(DIV_W);
  localparam int RAD_W       = 2 * SAMPLE_BITS;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

  localparam logic [WIN_W-1:0]  WINDOW_LEN_RESET  = 16'd8000;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 18'd16000;

  // Totals of one finished window, handed from front to back.
  typedef struct packed {
    logic [WNUM_W-1:0]       window_number;
    logic [SAMPLE_BITS-1:0]  peak;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_ACC_W-1:0]     sumsq;
    logic [CNT_W-1:0]        crossings;
    logic [WIN_W-1:0]        n;
    logic [RATE_W-1:0]       rate;
  } win_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic two_free;
  } q_status_t;

endpackage

// File: rtl/window_audio_level_stats_top.sv
// Top level of the windowed audio level statistics block.
// Holds configuration registers and wires front, queue and back. Depends on wals_pkg.
//
// Accepts one signed Q1.15 sample per cycle on a valid/ready channel and, at
// the last sample of each window of window_len samples, issues one request
// on the output channel carrying the window number (first is 1, wraps), the
// peak magnitude, the RMS (integer square root of the floor of the mean
// square), the DC mean (truncated toward zero) and the zero-crossing rate
// (crossings times the configured rate in hertz over the window length,
// floored). A window length of zero acts as one. Samples flow through a
// two-stage accumulator front end; finished window totals wait in a
// QUEUE_DEPTH-entry queue; the back end turns one record into results with
// a shared restoring divider that produces one quotient bit per cycle over
// three 46-bit divides, plus a 16-step square root and control overhead.
// Input samples are taken every cycle as long as the queue has room, so
// windows longer than the back end's turnaround run at full rate
// indefinitely; shorter windows are accepted at full rate until the queue
// fills and then only as fast as the back end finishes records.
// Write configuration only while the block is idle.
module window_audio_level_stats_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [wals_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wals_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [wals_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [wals_pkg::WNUM_W-1:0]              window_number,
  output logic [wals_pkg::OUT_W-1:0]               peak,
  output logic [wals_pkg::OUT_W-1:0]               rms,
  output logic signed [wals_pkg::OUT_W-1:0]        dc_mean,
  output logic [wals_pkg::ZC_W-1:0]                zero_cross_hz
);
  import wals_pkg::*;

  logic [WIN_W-1:0]  window_len;
  logic [RATE_W-1:0] rate_hz;

  // Configuration writes; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      rate_hz    <= SAMPLE_RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LEN:  window_len <= cfg_data[WIN_W-1:0];
        REG_SAMPLE_RATE: rate_hz    <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic      take;
  logic      pending;
  logic      push;
  logic      pop;
  win_rec_t  push_rec;
  win_rec_t  head_rec;
  q_status_t q_status;

  // Accept a sample only when the queue can absorb every window end still in
  // flight: the one in the front pipeline and the one being accepted now.
  assign in_ready = pending ? q_status.two_free : !q_status.full;
  assign take     = in_valid && in_ready;

  wals_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .sample     (sample),
    .window_len (window_len),
    .rate_hz    (rate_hz),
    .pending    (pending),
    .push       (push),
    .rec        (push_rec)
  );

  wals_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_rec),
    .pop     (pop),
    .rd_data (head_rec),
    .status  (q_status)
  );

  wals_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .rec           (head_rec),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .window_number (window_number),
    .peak          (peak),
    .rms           (rms),
    .dc_mean       (dc_mean),
    .zero_cross_hz (zero_cross_hz)
  );

endmodule

// File: rtl/wals_front.sv
// Front end: per-sample accumulation of peak, sum, sum of squares and crossings.
// Pushes one window record at each window end. Depends on wals_pkg.
module wals_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic signed [wals_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [wals_pkg::WIN_W-1:0]             window_len,
  input  logic [wals_pkg::RATE_W-1:0]            rate_hz,
  output logic                                   pending,
  output logic                                   push,
  output wals_pkg::win_rec_t                     rec
);
  import wals_pkg::*;

  // Stage 1: magnitude and square.
  logic                          s1_valid;
  logic                          s1_neg;
  logic [SAMPLE_BITS-1:0]        s1_mag;
  logic [SQ_W-1:0]               s1_sq;
  logic signed [SAMPLE_BITS-1:0] s1_val;

  logic                   in_neg;
  logic [SAMPLE_BITS-1:0] in_mag;
  logic [RAD_W-1:0]       in_mag_sq;

  assign in_neg    = sample[SAMPLE_BITS-1];
  assign in_mag    = in_neg ? (~sample + 1'b1) : sample;
  assign in_mag_sq = in_mag * in_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1_neg <= in_neg;
      s1_mag <= in_mag;
      s1_sq  <= in_mag_sq[SQ_W-1:0];
      s1_val <= sample;
    end
  end

  assign pending = s1_valid;

  // Stage 2: accumulators.
  logic [SAMPLE_BITS-1:0]  peak_acc;
  logic signed [SUM_W-1:0] sum_acc;
  logic [SQ_ACC_W-1:0]     square_acc;
  logic [CNT_W-1:0]        crossing_count;
  logic                    prev_negative;
  logic [WIN_W-1:0]        sample_index;
  logic [WNUM_W-1:0]       window_count;

  logic [WIN_W:0]          idx_next;
  logic [WIN_W-1:0]        len_eff;
  logic                    last;
  logic                    crossed;
  logic [SAMPLE_BITS-1:0]  peak_next;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_ACC_W-1:0]     square_next;
  logic [CNT_W-1:0]        crossing_next;

  always_comb begin
    idx_next      = {1'b0, sample_index} + 1'b1;
    len_eff       = (window_len == '0) ? WIN_W'(1) : window_len;
    last          = idx_next >= {1'b0, len_eff};
    crossed       = (sample_index != '0) && (s1_neg != prev_negative);
    peak_next     = (s1_mag > peak_acc) ? s1_mag : peak_acc;
    sum_next      = sum_acc + SUM_W'(s1_val);
    square_next   = square_acc + SQ_ACC_W'(s1_sq);
    crossing_next = crossing_count + CNT_W'(crossed);
  end

  assign push = s1_valid && last;

  always_comb begin
    rec.window_number = window_count + 1'b1;
    rec.peak          = peak_next;
    rec.sum           = sum_next;
    rec.sumsq         = square_next;
    rec.crossings     = crossing_next;
    rec.n             = idx_next[WIN_W-1:0];
    rec.rate          = rate_hz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_acc       <= '0;
      sum_acc        <= '0;
      square_acc     <= '0;
      crossing_count <= '0;
      prev_negative  <= 1'b0;
      sample_index   <= '0;
      window_count   <= '0;
    end else if (s1_valid) begin
      if (last) begin
        peak_acc       <= '0;
        sum_acc        <= '0;
        square_acc     <= '0;
        crossing_count <= '0;
        prev_negative  <= 1'b0;
        sample_index   <= '0;
        window_count   <= window_count + 1'b1;
      end else begin
        peak_acc       <= peak_next;
        sum_acc        <= sum_next;
        square_acc     <= square_next;
        crossing_count <= crossing_next;
        prev_negative  <= s1_neg;
        sample_index   <= idx_next[WIN_W-1:0];
      end
    end
  end

endmodule

// File: rtl/wals_queue.sv
// Short queue of finished window records between front and back.
// Depends on wals_pkg.
module wals_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wals_pkg::win_rec_t  wr_data,
  input  logic                pop,
  output wals_pkg::win_rec_t  rd_data,
  output wals_pkg::q_status_t status
);
  import wals_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  win_rec_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;

  assign rd_data         = entries[rd_ptr];
  assign status.empty    = (level == '0);
  assign status.full     = (level == LVL_W'(DEPTH));
  assign status.two_free = (level <= LVL_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !status.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue pop while empty");

endmodule

// File: rtl/wals_back.sv
// Back end: shared restoring divider and digit-by-digit square root that turn
// a window record into peak, RMS, DC mean and crossing rate. Depends on wals_pkg.
module wals_back (
  input  logic                             clk,
  input  logic                             rst,
  input  wals_pkg::q_status_t              q_status,
  input  wals_pkg::win_rec_t               rec,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wals_pkg::WNUM_W-1:0]      window_number,
  output logic [wals_pkg::OUT_W-1:0]       peak,
  output logic [wals_pkg::OUT_W-1:0]       rms,
  output logic signed [wals_pkg::OUT_W-1:0] dc_mean,
  output logic [wals_pkg::ZC_W-1:0]        zero_cross_hz
);
  import wals_pkg::*;

  localparam int SB = SAMPLE_BITS;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SQ_DIV  = 7'b0000010,
    ST_SUM_DIV = 7'b0000100,
    ST_ZC_MUL  = 7'b0001000,
    ST_ZC_DIV  = 7'b0010000,
    ST_SQRT    = 7'b0100000,
    ST_OUT     = 7'b1000000
  } state_t;

  state_t            state;
  win_rec_t          cur;
  logic [DIV_W-1:0]  div_q;
  logic [WIN_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [SQ_W-1:0]   msq;
  logic [OUT_W-1:0]  dc_r;
  logic [ZC_W-1:0]   zc_r;
  logic [RAD_W-1:0]  rad;
  logic [SB:0]       srem;
  logic [SB-1:0]     root;

  // Divider step: one quotient bit per cycle.
  logic [WIN_W:0]    div_rem_sh;
  logic [WIN_W:0]    div_diff;
  logic              div_ge;
  logic [WIN_W-1:0]  rem_next;
  logic [DIV_W-1:0]  div_q_next;
  logic              div_done;

  // Square root step: one result bit per cycle.
  logic [SB+2:0]     sq_sh;
  logic [SB+2:0]     sq_trial;
  logic [SB+2:0]     sq_diff;
  logic              sq_ge;
  logic [SB:0]       srem_next;
  logic [SB-1:0]     root_next;

  logic [SUM_W-1:0]  sum_mag;
  logic [OUT_W-1:0]  dc_q;
  logic [PROD_W-1:0] zc_prod;
  logic              load_out;

  always_comb begin
    div_rem_sh = {rem, div_q[DIV_W-1]};
    div_diff   = div_rem_sh - {1'b0, cur.n};
    div_ge     = div_rem_sh >= {1'b0, cur.n};
    rem_next   = div_ge ? div_diff[WIN_W-1:0] : div_rem_sh[WIN_W-1:0];
    div_q_next = {div_q[DIV_W-2:0], div_ge};
    div_done   = (step == STEP_W'(DIV_W - 1));

    sq_sh      = {srem, rad[RAD_W-1 -: 2]};
    sq_trial   = {1'b0, root, 2'b01};
    sq_diff    = sq_sh - sq_trial;
    sq_ge      = sq_sh >= sq_trial;
    srem_next  = sq_ge ? sq_diff[SB:0] : sq_sh[SB:0];
    root_next  = {root[SB-2:0], sq_ge};

    sum_mag    = cur.sum[SUM_W-1] ? (~cur.sum + 1'b1) : cur.sum;
    dc_q       = cur.sum[SUM_W-1] ? (~div_q_next[OUT_W-1:0] + 1'b1)
                                  : div_q_next[OUT_W-1:0];
    zc_prod    = cur.crossings * cur.rate;
  end

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign load_out = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_SQ_DIV;
          end
        end
        ST_SQ_DIV: begin
          if (div_done) begin
            state <= ST_SUM_DIV;
          end
        end
        ST_SUM_DIV: begin
          if (div_done) begin
            state <= ST_ZC_MUL;
          end
        end
        ST_ZC_MUL: begin
          state <= ST_ZC_DIV;
        end
        ST_ZC_DIV: begin
          if (div_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (step == STEP_W'(SB - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          cur   <= rec;
          div_q <= DIV_W'(rec.sumsq);
          rem   <= '0;
          step  <= '0;
        end
      end
      ST_SQ_DIV: begin
        if (div_done) begin
          msq   <= div_q_next[SQ_W-1:0];
          div_q <= DIV_W'(sum_mag);
          rem   <= '0;
          step  <= '0;
        end else begin
          div_q <= div_q_next;
          rem   <= rem_next;
          step  <= step + 1'b1;
        end
      end
      ST_SUM_DIV: begin
        if (div_done) begin
          dc_r <= dc_q;
        end else begin
          div_q <= div_q_next;
          rem   <= rem_next;
          step  <= step + 1'b1;
        end
      end
      ST_ZC_MUL: begin
        div_q <= DIV_W'(zc_prod);
        rem   <= '0;
        step  <= '0;
      end
      ST_ZC_DIV: begin
        if (div_done) begin
          zc_r <= div_q_next[ZC_W-1:0];
          rad  <= {1'b0, msq};
          srem <= '0;
          root <= '0;
          step <= '0;
        end else begin
          div_q <= div_q_next;
          rem   <= rem_next;
          step  <= step + 1'b1;
        end
      end
      ST_SQRT: begin
        rad  <= {rad[RAD_W-3:0], 2'b00};
        srem <= srem_next;
        root <= root_next;
        step <= step + 1'b1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      window_number <= cur.window_number;
      peak          <= OUT_W'(cur.peak);
      rms           <= OUT_W'(root);
      dc_mean       <= dc_r;
      zero_cross_hz <= zc_r;
    end
  end

  a_rms_le_peak: assert property (@(posedge clk) disable iff (rst)
    load_out |=> rms <= peak)
    else $error("rms exceeds peak");

  a_zc_le_rate: assert property (@(posedge clk) disable iff (rst)
    load_out |=> zero_cross_hz <= cur.rate)
    else $error("crossing rate exceeds sample rate");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_SQ_DIV)
    else $error("record popped without starting the divide");

endmodule

// File: tb/tb_window_audio_level_stats_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for window_audio_level_stats_top: directed and random
// sample streams, a local model of the window statistics, per-field result checks.
// Depends on wals_pkg and the RTL of the block only.
module tb_window_audio_level_stats_top;
  import wals_pkg::*;

  // Register indexes the block does not decode; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 16'sh7FFF;

  // Leave the back end time to finish its last window, with margin, before
  // touching the registers or ending the run.
  localparam int QUIET_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 800;

  // Content shapes for random sample runs.
  typedef enum {STYLE_FULL, STYLE_QUIET, STYLE_RAIL, STYLE_HIGH, STYLE_LOW} sample_style_t;

  typedef struct {
    logic [WNUM_W-1:0]        window_number;
    logic [OUT_W-1:0]         peak;
    logic [OUT_W-1:0]         rms;
    logic signed [OUT_W-1:0]  dc_mean;
    logic [ZC_W-1:0]          zero_cross_hz;
  } window_stats_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          out_valid;
  logic                          out_ready;
  logic [WNUM_W-1:0]             window_number;
  logic [OUT_W-1:0]              peak;
  logic [OUT_W-1:0]              rms;
  logic signed [OUT_W-1:0]       dc_mean;
  logic [ZC_W-1:0]               zero_cross_hz;

  // Expected window results, oldest first.
  window_stats_t pending_windows[$];
  int failures = 0;

  // Idle controls shared by the sender task and the receiver process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // Local copy of the block's registers and running window totals.
  logic [WIN_W-1:0]  len_cfg = WINDOW_LEN_RESET;
  logic [RATE_W-1:0] rate_cfg = SAMPLE_RATE_RESET;
  logic [16:0]       peak_mag = '0;
  longint            sum_total = 0;
  longint unsigned   square_total = 0;
  int unsigned       crossings = 0;
  int unsigned       taken = 0;
  bit                last_negative = 1'b0;
  logic [WNUM_W-1:0] windows_done = '0;

  window_audio_level_stats_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .window_number (window_number),
    .peak          (peak),
    .rms           (rms),
    .dc_mean       (dc_mean),
    .zero_cross_hz (zero_cross_hz)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bitwise integer square root, floor.
  function automatic logic [OUT_W-1:0] square_root(input longint unsigned v);
    logic [OUT_W-1:0] r;
    longint unsigned t;
    r = '0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      t = longint'(r | (16'd1 << b));
      if (t * t <= v) r = r | (16'd1 << b);
    end
    return r;
  endfunction

  // Fold one accepted sample into the window totals; at the window's end,
  // queue the expected result and clear the totals.
  function automatic void accumulate_sample(input logic signed [SAMPLE_BITS-1:0] s);
    bit neg;
    longint v;
    longint unsigned mag;
    longint n;
    longint unsigned limit;
    window_stats_t w;
    neg = s[SAMPLE_BITS-1];
    v = s;
    mag = neg ? -v : v;
    // The first sample of a window is its own predecessor.
    if (taken != 0 && neg != last_negative) crossings++;
    last_negative = neg;
    if (mag > peak_mag) peak_mag = mag;
    sum_total += v;
    square_total += mag * mag;
    taken++;
    // A zero length acts as one; a window ends once the count reaches or
    // passes the length, even if the length dropped mid-window.
    limit = (len_cfg == 0) ? 1 : len_cfg;
    if (taken < limit) return;
    n = taken;
    windows_done++;
    w.window_number = windows_done;
    w.peak = peak_mag[OUT_W-1:0];
    w.rms = square_root(square_total / n);
    w.dc_mean = 16'(sum_total / n);
    w.zero_cross_hz = 18'((longint'(crossings) * rate_cfg) / n);
    pending_windows.push_back(w);
    peak_mag = '0;
    sum_total = 0;
    square_total = 0;
    crossings = 0;
    taken = 0;
    last_negative = 1'b0;
  endfunction

  function automatic void compare_field(input string name, input longint expv,
                                        input longint actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      failures++;
    end
  endfunction

  // Check every output request against the oldest expected window.
  always @(posedge clk) begin : check_results
    window_stats_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_windows.size() == 0) begin
        $error("window_number mismatch: expected none, got %0d", window_number);
        failures++;
      end else begin
        w = pending_windows.pop_front();
        compare_field("window_number", w.window_number, window_number);
        compare_field("peak", w.peak, peak);
        compare_field("rms", w.rms, rms);
        compare_field("dc_mean", w.dc_mean, dc_mean);
        compare_field("zero_cross_hz", w.zero_cross_hz, zero_cross_hz);
      end
    end
  end

  // Receiver: stall at random, or hold off for a counted stretch on request.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one sample request and return at the edge that accepts it. Valid
  // stays high on return so the next call can follow without a gap; settle
  // drops it, and every register write is made after a settle.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    accumulate_sample(s);
  endtask

  // Drop valid, wait for every expected window, then let the back end go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // One register write; only call with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WINDOW_LEN) len_cfg = data[WIN_W-1:0];
    else if (idx == REG_SAMPLE_RATE) rate_cfg = data[RATE_W-1:0];
  endtask

  task automatic configure(input logic [WIN_W-1:0] len, input logic [RATE_W-1:0] rate);
    settle();
    write_reg(REG_WINDOW_LEN, 18'(len));
    write_reg(REG_SAMPLE_RATE, rate);
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 18'd1;
      2: return 18'd192000;
      3: return '1;
      default: return 18'($urandom_range(1, 192000));
    endcase
  endfunction

  // Mostly short windows so results come often; a few of 150 to 220 samples,
  // mostly longer than the back end's turnaround, so the input runs near full rate.
  function automatic logic [WIN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 70) return 16'($urandom_range(1, 12));
    if (r < 92) return 16'($urandom_range(13, 60));
    return 16'($urandom_range(150, 220));
  endfunction

  function automatic sample_style_t pick_style();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return STYLE_FULL;
    if (r < 65) return STYLE_QUIET;
    if (r < 80) return STYLE_RAIL;
    if (r < 90) return STYLE_HIGH;
    return STYLE_LOW;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input sample_style_t style);
    int v;
    case (style)
      STYLE_QUIET: v = $urandom_range(0, 8) - 4;        // hover around the sign boundary
      STYLE_RAIL: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      STYLE_HIGH: v = $urandom_range(20000, 32767);
      STYLE_LOW: v = -int'($urandom_range(20000, 32768));
      default: v = $urandom_range(0, 65535);
    endcase
    return 16'(v);
  endfunction

  // Samples at the reset settings, then shrink the window below the count
  // already taken so the next sample ends it.
  task automatic test_reset_window();
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    settle();
    write_reg(REG_WINDOW_LEN, 18'd2);
    send_sample(16'sd1);
  endtask

  // Upper data bits beyond a register's width and undecoded indexes are dropped.
  task automatic test_register_map();
    settle();
    write_reg(REG_WINDOW_LEN, 18'h30003);
    write_reg(REG_SAMPLE_RATE, '1);
    write_reg(REG_UNUSED_2, '1);
    write_reg(REG_UNUSED_3, 18'h00005);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    send_sample(16'sd7);
  endtask

  // Zero length: every sample is a window. Zero rate: no crossing rate.
  task automatic test_zero_length();
    configure(16'd0, 18'd0);
    send_sample(-16'sd1);
    send_sample(16'sd12345);
  endtask

  task automatic test_full_scale();
    configure(16'hFFFF, 18'd192000);
    repeat (3) send_sample(FULL_NEG);
    settle();
    write_reg(REG_WINDOW_LEN, 18'd1);
    send_sample(FULL_NEG);
    settle();
    write_reg(REG_WINDOW_LEN, 18'd4);
    repeat (4) send_sample(FULL_POS);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(-16'sd1);
  endtask

  // Hold the receiver off while samples keep coming so the queue fills and
  // the input stalls; then pause with a window half done until all drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(16'd1, pick_rate());
    hold_request = HOLD_OFF_CYCLES;
    repeat (40) send_sample(next_sample(STYLE_FULL));
    configure(16'd3, pick_rate());
    repeat (10) send_sample(next_sample(STYLE_QUIET));
    settle();
    repeat (8) send_sample(next_sample(STYLE_QUIET));
  endtask

  // Random segments; each picks a length, rate and sample shape. Segments end
  // at random points inside a window, so the next length change often lands
  // mid-window.
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int target);
    int sent;
    int eff_len;
    int span;
    sample_style_t style;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < target) begin
      configure(pick_length(), pick_rate());
      eff_len = (len_cfg == 0) ? 1 : len_cfg;
      span = (eff_len > 100) ? eff_len : eff_len * $urandom_range(1, 4);
      span += $urandom_range(0, eff_len / 2);
      style = pick_style();
      repeat (span) send_sample(next_sample(style));
      sent += span;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_register_map();
    test_zero_length();
    test_full_scale();
    test_backpressure();
    test_random_phase(0, 0, 465);
    test_random_phase(78, 0, 465);
    test_random_phase(0, 78, 465);
    test_random_phase(15, 15, 465);

    settle();
    if (failures == 0 && pending_windows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: window_audio_level_stats_top.f
rtl/wals_pkg.sv
rtl/wals_front.sv
rtl/wals_queue.sv
rtl/wals_back.sv
rtl/window_audio_level_stats_top.sv
tb/tb_window_audio_level_stats_top.sv
